// ===== rtl/gcode_line_parser_top_macros.svh =====
// Assertion macros for the G-code line parser checker.
// Needs signals named clock and reset in the including scope.
`ifndef GCODE_LINE_PARSER_TOP_MACROS_SVH
`define GCODE_LINE_PARSER_TOP_MACROS_SVH

// same-cycle implication
`define GLP_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define GLP_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

// ===== rtl/glp_pkg.sv =====
// Shared types, codes and the decimal scale table of the G-code line parser.
// No dependencies.
package glp_pkg;

   localparam logic [2:0] CLS_NONE = 3'd0;
   localparam logic [2:0] CLS_G    = 3'd1;
   localparam logic [2:0] CLS_M    = 3'd2;
   localparam logic [2:0] CLS_T    = 3'd3;
   localparam logic [2:0] CLS_S    = 3'd4;

   localparam logic [2:0] AX_X    = 3'd0;
   localparam logic [2:0] AX_Y    = 3'd1;
   localparam logic [2:0] AX_Z    = 3'd2;
   localparam logic [2:0] AX_E    = 3'd3;
   localparam logic [2:0] AX_F    = 3'd4;
   localparam logic [2:0] AX_NONE = 3'd5;

   localparam int NUM_AXES = 5;

   // one classified character beat, front to back
   typedef struct packed {
      logic       nl;
      logic       zero;
      logic       space;
      logic       digit;
      logic [3:0] dval;
      logic       dot;
      logic       minus;
      logic       plus;
      logic [2:0] cls;
      logic [2:0] axis;
      logic       eol;
      logic       cut;
   } glp_beat_type;

   // one parsed line
   typedef struct packed {
      logic [2:0]                    cls;
      logic [13:0]                   number;
      logic [NUM_AXES-1:0][31:0]     vals;
      logic [NUM_AXES-1:0]           mask;
      logic                          cut;
   } glp_rsp_type;

   function automatic logic [13:0] pow10(input logic [2:0] k);
      logic [13:0] r;
      case (k)
         3'd0:    r = 14'd1;
         3'd1:    r = 14'd10;
         3'd2:    r = 14'd100;
         3'd3:    r = 14'd1000;
         3'd4:    r = 14'd10000;
         default: r = 14'd1;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/gcode_line_parser_top.sv =====
// G-code line parser: takes one character per cycle while full is low and
// emits one parsed command per line. The front classifies characters and
// counts the line length; a two-beat queue feeds the token state machine,
// whose finished tokens are scaled by a single 32x14 multiply in a commit
// stage. Results leave through a two-beat queue, so the input keeps flowing
// while a result waits. Sustained rate is one character per cycle when nothing
// is stalled; the beat ending a line (newline or the LINE_MAX-th byte) goes
// through the beat queue and the commit stage register before the result is queued.
// Depends on glp_pkg, glp_fifo, glp_front and glp_back.
module gcode_line_parser_top
   import glp_pkg::*;
#(
   parameter int LINE_MAX    = 256,
   parameter int FRAC_DIGITS = 3
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  logic [7:0]         req_in_char,
   output logic               empty,
   input  logic               pop,
   output logic [2:0]         rsp_cmd_class,
   output logic [13:0]        rsp_cmd_number,
   output logic signed [31:0] rsp_x_value,
   output logic signed [31:0] rsp_y_value,
   output logic signed [31:0] rsp_z_value,
   output logic signed [31:0] rsp_e_value,
   output logic signed [31:0] rsp_f_value,
   output logic [4:0]         rsp_present_mask,
   output logic               rsp_line_cut
);

   localparam int BEAT_W = $bits(glp_beat_type);
   localparam int RSP_W  = $bits(glp_rsp_type);

   glp_beat_type fr_beat, bk_beat;
   logic         fr_push, q_empty, bk_pop;
   logic [BEAT_W-1:0] q_rdata;
   glp_rsp_type  bk_rsp, out_rsp;
   logic         res_push, res_full;
   logic [RSP_W-1:0] r_rdata;

   glp_front #(.LINE_MAX(LINE_MAX)) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_push   (push),
      .in_char   (req_in_char),
      .q_full    (full),
      .beat_push (fr_push),
      .beat      (fr_beat)
   );

   glp_fifo #(.WIDTH(BEAT_W), .DEPTH(2)) u_beat_q (
      .clock (clock),
      .reset (reset),
      .push  (fr_push),
      .wdata (fr_beat),
      .full  (full),
      .pop   (bk_pop),
      .rdata (q_rdata),
      .empty (q_empty)
   );

   assign bk_beat = glp_beat_type'(q_rdata);

   glp_back #(.FRAC_DIGITS(FRAC_DIGITS)) u_back (
      .clock      (clock),
      .reset      (reset),
      .beat_valid (!q_empty),
      .beat       (bk_beat),
      .beat_pop   (bk_pop),
      .res_full   (res_full),
      .res_push   (res_push),
      .res_data   (bk_rsp)
   );

   glp_fifo #(.WIDTH(RSP_W), .DEPTH(2)) u_rsp_q (
      .clock (clock),
      .reset (reset),
      .push  (res_push),
      .wdata (bk_rsp),
      .full  (res_full),
      .pop   (pop),
      .rdata (r_rdata),
      .empty (empty)
   );

   assign out_rsp          = glp_rsp_type'(r_rdata);
   assign rsp_cmd_class    = out_rsp.cls;
   assign rsp_cmd_number   = out_rsp.number;
   assign rsp_x_value      = $signed(out_rsp.vals[AX_X]);
   assign rsp_y_value      = $signed(out_rsp.vals[AX_Y]);
   assign rsp_z_value      = $signed(out_rsp.vals[AX_Z]);
   assign rsp_e_value      = $signed(out_rsp.vals[AX_E]);
   assign rsp_f_value      = $signed(out_rsp.vals[AX_F]);
   assign rsp_present_mask = out_rsp.mask;
   assign rsp_line_cut     = out_rsp.cut;

endmodule

// ===== rtl/glp_fifo.sv =====
// Small register queue used between the parser stages and at the result side.
// No dependencies.
module glp_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wdata,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] rdata,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0]    cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign full    = (cnt_ff == CW'(DEPTH));
   assign empty   = (cnt_ff == '0);
   assign do_push = push && !full;
   assign do_pop  = pop && !empty;
   assign rdata   = mem_ff[rd_ff];

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= wdata;
      end
   end

endmodule

// ===== rtl/glp_front.sv =====
// Front end: accepts characters, classifies them and tracks the line length.
// Depends on glp_pkg.
module glp_front
   import glp_pkg::*;
#(
   parameter int LINE_MAX = 256
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         in_push,
   input  logic [7:0]   in_char,
   input  logic         q_full,
   output logic         beat_push,
   output glp_beat_type beat
);

   localparam int CW = $clog2(LINE_MAX);

   localparam logic [7:0] CH_NL    = 8'd10;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_0     = 8'h30;
   localparam logic [7:0] CH_9     = 8'h39;

   logic [CW-1:0] count_ff, count_in;
   logic          last;

   assign beat_push = in_push && !q_full;
   assign last      = (count_ff == CW'(LINE_MAX - 1));

   always_comb begin
      beat       = '0;
      beat.nl    = (in_char == CH_NL);
      beat.zero  = (in_char == 8'd0);
      beat.space = (in_char == CH_SPACE);
      beat.digit = (in_char >= CH_0) && (in_char <= CH_9);
      beat.dval  = in_char[3:0];
      beat.dot   = (in_char == CH_DOT);
      beat.minus = (in_char == CH_MINUS);
      beat.plus  = (in_char == CH_PLUS);
      unique case (in_char)
         "G":     beat.cls = CLS_G;
         "M":     beat.cls = CLS_M;
         "T":     beat.cls = CLS_T;
         "S":     beat.cls = CLS_S;
         default: beat.cls = CLS_NONE;
      endcase
      unique case (in_char)
         "X":     beat.axis = AX_X;
         "Y":     beat.axis = AX_Y;
         "Z":     beat.axis = AX_Z;
         "E":     beat.axis = AX_E;
         "F":     beat.axis = AX_F;
         default: beat.axis = AX_NONE;
      endcase
      beat.eol = beat.nl || last;
      beat.cut = !beat.nl && last;
   end

   always_comb begin
      count_in = count_ff;
      if (beat_push) begin
         count_in = beat.eol ? '0 : count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

endmodule

// ===== rtl/glp_back.sv =====
// Back end: token state machine, then a commit stage that scales the value,
// updates the axis registers and emits the line. Depends on glp_pkg.
module glp_back
   import glp_pkg::*;
#(
   parameter int FRAC_DIGITS = 3
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         beat_valid,
   input  glp_beat_type beat,
   output logic         beat_pop,
   input  logic         res_full,
   output logic         res_push,
   output glp_rsp_type  res_data
);

   localparam int FDW = $clog2(FRAC_DIGITS + 1);
   localparam logic [2:0] FRAC_K = 3'(FRAC_DIGITS);
   localparam logic [35:0] MAG_CAP = 36'h0_8000_0000;

   localparam logic [1:0] PH_SIGN = 2'd0;
   localparam logic [1:0] PH_INT  = 2'd1;
   localparam logic [1:0] PH_FRAC = 2'd2;
   localparam logic [1:0] PH_STOP = 2'd3;

   typedef struct packed {
      logic           commit;
      logic [2:0]     axis;
      logic [31:0]    acc;
      logic           neg;
      logic [FDW-1:0] fd;
      logic           eol;
      logic [2:0]     cls;
      logic [13:0]    number;
      logic           cut;
   } commit_type;

   // token stage
   logic           first_ff, first_in, tok_ff, tok_in, ended_ff, ended_in;
   logic [2:0]     axis_ff, axis_in, cls_ff, cls_in;
   logic [1:0]     phase_ff, phase_in;
   logic           neg_ff, neg_in;
   logic [FDW-1:0] fd_ff, fd_in;
   logic [31:0]    acc_ff, acc_in;
   logic [13:0]    num_ff, num_in;

   logic           fin_feed, fin, takes;
   logic [35:0]    acc_wide;
   logic [31:0]    acc_step;
   logic [16:0]    num_wide;
   logic [13:0]    num_step;
   commit_type     cm;

   // commit stage
   logic                      b_valid_ff;
   commit_type                b_ff;
   logic [NUM_AXES-1:0][31:0] vals_ff, vals_mrg;
   logic [NUM_AXES-1:0]       mask_ff, mask_mrg;
   logic [13:0]               scale;
   logic [45:0]               prod;
   logic [31:0]               fixed;
   logic                      stall, adv;

   assign stall    = b_valid_ff && b_ff.eol && res_full;
   assign adv      = beat_valid && !stall;
   assign beat_pop = adv;

   assign acc_wide = {1'b0, acc_ff, 3'b000} + {3'b000, acc_ff, 1'b0} + 36'(beat.dval);
   assign acc_step = (acc_wide > MAG_CAP) ? MAG_CAP[31:0] : acc_wide[31:0];
   assign num_wide = {num_ff, 3'b000} + {2'b00, num_ff, 1'b0} + 17'(beat.dval);
   assign num_step = (num_wide > 17'd9999) ? 14'd9999 : num_wide[13:0];

   always_comb begin
      tok_in   = tok_ff;
      axis_in  = axis_ff;
      phase_in = phase_ff;
      neg_in   = neg_ff;
      fd_in    = fd_ff;
      acc_in   = acc_ff;
      cls_in   = cls_ff;
      num_in   = num_ff;
      ended_in = ended_ff;
      fin_feed = 1'b0;
      if (!beat.nl && !ended_ff) begin
         if (beat.zero) begin
            fin_feed = 1'b1;
            ended_in = 1'b1;
         end else if (beat.space) begin
            fin_feed = 1'b1;
         end else if (!tok_ff) begin
            tok_in   = 1'b1;
            axis_in  = beat.axis;
            phase_in = PH_SIGN;
            neg_in   = 1'b0;
            fd_in    = '0;
            acc_in   = '0;
            if (first_ff) begin
               cls_in = beat.cls;
               num_in = '0;
            end
         end else if (first_ff) begin
            if (phase_ff == PH_SIGN && beat.digit) begin
               num_in = num_step;
            end else begin
               phase_in = PH_STOP;
            end
         end else begin
            unique case (phase_ff)
               PH_SIGN: begin
                  if (beat.minus || beat.plus) begin
                     neg_in   = beat.minus;
                     phase_in = PH_INT;
                  end else if (beat.digit) begin
                     acc_in   = acc_step;
                     phase_in = PH_INT;
                  end else if (beat.dot) begin
                     phase_in = PH_FRAC;
                  end else begin
                     phase_in = PH_STOP;
                  end
               end
               PH_INT: begin
                  if (beat.digit) begin
                     acc_in = acc_step;
                  end else if (beat.dot) begin
                     phase_in = PH_FRAC;
                  end else begin
                     phase_in = PH_STOP;
                  end
               end
               PH_FRAC: begin
                  if (beat.digit) begin
                     if (3'(fd_ff) < FRAC_K) begin
                        acc_in = acc_step;
                        fd_in  = fd_ff + 1'b1;
                     end
                  end else begin
                     phase_in = PH_STOP;
                  end
               end
               PH_STOP: begin
               end
            endcase
         end
      end

      fin   = (fin_feed || beat.eol) && tok_in;
      takes = (cls_in == CLS_G && (num_in == 14'd0 || num_in == 14'd1 || num_in == 14'd92))
              || (cls_in == CLS_M && num_in == 14'd32);

      cm.commit = fin && !first_ff && takes && (axis_in != AX_NONE);
      cm.axis   = axis_in;
      cm.acc    = acc_in;
      cm.neg    = neg_in;
      cm.fd     = fd_in;
      cm.eol    = beat.eol;
      cm.cls    = cls_in;
      cm.number = num_in;
      cm.cut    = beat.cut;

      first_in = first_ff && !fin;
      if (fin) begin
         tok_in = 1'b0;
      end
      if (beat.eol) begin
         first_in = 1'b1;
         tok_in   = 1'b0;
         axis_in  = AX_NONE;
         phase_in = PH_SIGN;
         neg_in   = 1'b0;
         fd_in    = '0;
         acc_in   = '0;
         cls_in   = CLS_NONE;
         num_in   = '0;
         ended_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         first_ff <= 1'b1;
         tok_ff   <= 1'b0;
         axis_ff  <= AX_NONE;
         phase_ff <= PH_SIGN;
         neg_ff   <= 1'b0;
         fd_ff    <= '0;
         acc_ff   <= '0;
         cls_ff   <= CLS_NONE;
         num_ff   <= '0;
         ended_ff <= 1'b0;
      end else if (adv) begin
         first_ff <= first_in;
         tok_ff   <= tok_in;
         axis_ff  <= axis_in;
         phase_ff <= phase_in;
         neg_ff   <= neg_in;
         fd_ff    <= fd_in;
         acc_ff   <= acc_in;
         cls_ff   <= cls_in;
         num_ff   <= num_in;
         ended_ff <= ended_in;
      end
   end

   // scale missing fraction digits, then clamp to the signed 32-bit range
   assign scale = pow10(FRAC_K - 3'(b_ff.fd));
   assign prod  = 46'(b_ff.acc) * 46'(scale);

   always_comb begin
      if (b_ff.neg) begin
         fixed = (prod >= 46'(MAG_CAP)) ? 32'h8000_0000 : 32'd0 - prod[31:0];
      end else begin
         fixed = (prod > 46'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : prod[31:0];
      end
      vals_mrg = vals_ff;
      mask_mrg = mask_ff;
      for (int i = 0; i < NUM_AXES; i++) begin
         if (b_ff.commit && b_ff.axis == 3'(i)) begin
            vals_mrg[i] = fixed;
            mask_mrg[i] = 1'b1;
         end
      end
   end

   assign res_push        = b_valid_ff && b_ff.eol && !res_full;
   assign res_data.cls    = b_ff.cls;
   assign res_data.number = b_ff.number;
   assign res_data.vals   = vals_mrg;
   assign res_data.mask   = mask_mrg;
   assign res_data.cut    = b_ff.cut;

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
         vals_ff    <= '0;
         mask_ff    <= '0;
      end else if (!stall) begin
         b_valid_ff <= adv;
         if (b_valid_ff) begin
            vals_ff <= b_ff.eol ? '0 : vals_mrg;
            mask_ff <= b_ff.eol ? '0 : mask_mrg;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         b_ff <= cm;
      end
   end

endmodule

// ===== rtl/glp_checker.sv =====
// Port-level checks for the G-code line parser, bound to the top level.
// Depends on glp_pkg and gcode_line_parser_top_macros.svh.
`include "gcode_line_parser_top_macros.svh"

module glp_checker
   import glp_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               empty,
   input logic               pop,
   input logic [2:0]         rsp_cmd_class,
   input logic [13:0]        rsp_cmd_number,
   input logic signed [31:0] rsp_x_value,
   input logic signed [31:0] rsp_y_value,
   input logic signed [31:0] rsp_z_value,
   input logic signed [31:0] rsp_e_value,
   input logic signed [31:0] rsp_f_value,
   input logic [4:0]         rsp_present_mask,
   input logic               rsp_line_cut
);

   logic         absent_ok;
   logic         no_args;
   logic [182:0] rsp_all;

   assign absent_ok = (rsp_present_mask[0] || rsp_x_value == '0)
                   && (rsp_present_mask[1] || rsp_y_value == '0)
                   && (rsp_present_mask[2] || rsp_z_value == '0)
                   && (rsp_present_mask[3] || rsp_e_value == '0)
                   && (rsp_present_mask[4] || rsp_f_value == '0);
   assign no_args   = (rsp_cmd_class != CLS_G) && (rsp_cmd_class != CLS_M);
   assign rsp_all   = {rsp_cmd_class, rsp_cmd_number, rsp_x_value, rsp_y_value,
                       rsp_z_value, rsp_e_value, rsp_f_value, rsp_present_mask,
                       rsp_line_cut};

   `GLP_ASSERT_NOW(a_number_sat, !empty, rsp_cmd_number <= 14'd9999, "command number above 9999")

   `GLP_ASSERT_NOW(a_absent_zero, !empty, absent_ok, "absent axis with nonzero value")

   `GLP_ASSERT_NOW(a_args_only_gm, !empty && no_args, rsp_present_mask == 5'd0, "stray arguments")

   `GLP_ASSERT_NEXT(a_rsp_hold, !empty && !pop, !empty && $stable(rsp_all), "waiting beat changed")

endmodule

bind gcode_line_parser_top glp_checker u_checker (.*);
